FILE: src/pura_pkg.sv
// ----------------------------------------------------------------------------
// pura_pkg
// shared types, formats and constants of the pose update core
// ----------------------------------------------------------------------------
package pura_pkg;

   // field formats
   localparam int POSITION_BITS  = 32;
   localparam int ANGLE_BITS     = 16;
   localparam int ROTATION_STEPS = 16;
   localparam int MAX_STEPS      = 24;

   // datapath formats
   localparam int GUARD_BITS = 8;
   localparam int LEN_BITS   = POSITION_BITS - 1;
   localparam int PROD_BITS  = LEN_BITS + 32;
   localparam int MAG_BITS   = LEN_BITS + GUARD_BITS;
   localparam int VEC_BITS   = MAG_BITS + 2;
   localparam int DELTA_BITS = VEC_BITS - GUARD_BITS;
   localparam int SUM_BITS   = POSITION_BITS + 2;
   localparam int Z_BITS     = 33;

   // limit cordic gain, unsigned q0.32
   localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

   localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

   localparam logic signed [VEC_BITS-1:0] ROUND_HALF = VEC_BITS'(1) << (GUARD_BITS - 1);

   localparam logic signed [SUM_BITS-1:0] POS_MAX =
      SUM_BITS'((SUM_BITS'(1) << (POSITION_BITS - 1)) - SUM_BITS'(1));
   localparam logic signed [SUM_BITS-1:0] POS_MIN = -POS_MAX - SUM_BITS'(1);

   // arctan(2^-i) in 2^32 units per turn
   localparam logic [31:0] ARCTAN_TURNS [MAX_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct packed {
      logic signed [POSITION_BITS-1:0] known_x;
      logic signed [POSITION_BITS-1:0] known_y;
      logic signed [ANGLE_BITS-1:0]    known_heading;
      logic        [LEN_BITS-1:0]      arc_length;
      logic signed [ANGLE_BITS-1:0]    arc_start_angle;
      logic signed [ANGLE_BITS-1:0]    arc_end_angle;
      logic                            target_is_start;
      logic signed [POSITION_BITS-1:0] prior_x;
      logic signed [POSITION_BITS-1:0] prior_y;
      logic signed [ANGLE_BITS-1:0]    prior_heading;
   } req_type;

   typedef struct packed {
      logic signed [POSITION_BITS-1:0] new_x;
      logic signed [POSITION_BITS-1:0] new_y;
      logic signed [ANGLE_BITS-1:0]    new_heading;
      logic                            pose_changed;
   } rsp_type;

   // fields that ride along the pipeline untouched
   typedef struct packed {
      logic signed [POSITION_BITS-1:0] kx;
      logic signed [POSITION_BITS-1:0] ky;
      logic        [POSITION_BITS-1:0] px;
      logic        [POSITION_BITS-1:0] py;
      logic        [ANGLE_BITS-1:0]    ph;
      logic        [ANGLE_BITS-1:0]    nh;
   } carry_type;

   typedef struct packed {
      carry_type                carry;
      logic                     flip;
      logic [MAG_BITS-1:0]      mag;
      logic signed [Z_BITS-1:0] z;
   } prep_type;

   typedef struct packed {
      carry_type                  carry;
      logic signed [VEC_BITS-1:0] vx;
      logic signed [VEC_BITS-1:0] vy;
      logic signed [Z_BITS-1:0]   z;
   } rot_type;

   typedef struct packed {
      carry_type                  carry;
      logic signed [SUM_BITS-1:0] sx;
      logic signed [SUM_BITS-1:0] sy;
   } sum_type;

endpackage

FILE: src/pura_rotate_stage.sv
// ----------------------------------------------------------------------------
// pura_rotate_stage
// one registered cordic micro-rotation with its own valid and ready
// ----------------------------------------------------------------------------
module pura_rotate_stage #(
   parameter int STEP = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  pura_pkg::rot_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output pura_pkg::rot_type  out_data
);

   logic                                 valid_ff;
   pura_pkg::rot_type                    data_ff;
   pura_pkg::rot_type                    data_in;
   logic signed [pura_pkg::VEC_BITS-1:0] sx;
   logic signed [pura_pkg::VEC_BITS-1:0] sy;
   logic signed [pura_pkg::Z_BITS-1:0]   atan;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      sx   = in_data.vx >>> STEP;
      sy   = in_data.vy >>> STEP;
      atan = pura_pkg::Z_BITS'(pura_pkg::ARCTAN_TURNS[STEP]);
      data_in       = in_data;
      // non-negative residual angle rotates counter-clockwise
      if (!in_data.z[pura_pkg::Z_BITS-1]) begin
         data_in.vx = in_data.vx - sy;
         data_in.vy = in_data.vy + sx;
         data_in.z  = in_data.z - atan;
      end else begin
         data_in.vx = in_data.vx + sy;
         data_in.vy = in_data.vy - sx;
         data_in.z  = in_data.z + atan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: src/pose_update_via_relative_arc_core.sv
// ----------------------------------------------------------------------------
// pose_update_via_relative_arc_core
// planar pose composition along a relative arc, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   each request carries a known landmark pose, an arc (length plus a twist
//   at each end, swapped when the target sits at the arc's from end) and the
//   target's current pose. one response comes back per request, in order,
//   with the target's new pose and a flag telling whether it moved
//   both channels are valid/ready; a request is taken when req_valid and
//   req_ready are high together, a response leaves on rsp_valid && rsp_ready
//   the registers in order hold angle maths and the gain multiply, vector
//   load, one cordic micro-rotation per stage, rounding and offset add, then
//   saturation and compare into the output register. throughput is one
//   request per cycle, as every stage takes a new request in each cycle
//   that its successor can move on
//   every stage has its own valid bit and a local ready, so bubbles close up
//   and requests keep entering while a finished response waits; a stalled
//   receiver fills the pipe stage by stage and then drops req_ready
//   synchronous reset empties all stages; no clearing pass is needed
// ----------------------------------------------------------------------------
module pose_update_via_relative_arc_core #(
   parameter int ROTATION_STEPS = pura_pkg::ROTATION_STEPS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pura_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pura_pkg::rsp_type rsp_data
);

   // ---------------------------------------------------------------------
   // stage 1: twist selection, heading, quadrant fold and gain multiply
   // ---------------------------------------------------------------------
   logic                                 prep_valid_ff;
   pura_pkg::prep_type                   prep_ff;
   pura_pkg::prep_type                   prep_in;
   logic                                 prep_ready;
   logic [pura_pkg::ANGLE_BITS-1:0]      near_tw;
   logic [pura_pkg::ANGLE_BITS-1:0]      far_tw;
   logic [pura_pkg::ANGLE_BITS-1:0]      heading;
   logic [31:0]                          turn;
   logic [pura_pkg::PROD_BITS-1:0]       product;
   logic                                 load_ready;

   always_comb begin
      // arc conjugate when the target is the from end
      near_tw = req_data.target_is_start ? req_data.arc_end_angle : req_data.arc_start_angle;
      far_tw  = req_data.target_is_start ? req_data.arc_start_angle : req_data.arc_end_angle;
      heading = req_data.known_heading - near_tw;

      // binary angle scaled up to 2^32 units per turn
      turn = {heading, {(32 - pura_pkg::ANGLE_BITS){1'b0}}};

      // length times the cordic gain, truncated to guard-bit precision
      product = pura_pkg::PROD_BITS'(req_data.arc_length)
              * pura_pkg::PROD_BITS'(pura_pkg::GAIN_Q32);

      prep_in.carry.kx = req_data.known_x;
      prep_in.carry.ky = req_data.known_y;
      prep_in.carry.px = req_data.prior_x;
      prep_in.carry.py = req_data.prior_y;
      prep_in.carry.ph = req_data.prior_heading;
      prep_in.carry.nh = heading - pura_pkg::HALF_TURN + far_tw;
      // second and third quadrants fold by half a turn
      prep_in.flip     = turn[31] ^ turn[30];
      prep_in.mag      = product[pura_pkg::PROD_BITS-1 -: pura_pkg::MAG_BITS];
      prep_in.z        = pura_pkg::Z_BITS'(signed'({turn[31] ^ prep_in.flip, turn[30:0]}));
   end

   assign prep_ready = !prep_valid_ff || load_ready;
   assign req_ready  = prep_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (prep_ready) begin
         prep_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (prep_ready && req_valid) begin
         prep_ff <= prep_in;
      end
   end

   // ---------------------------------------------------------------------
   // stage 2: start vector, negated for a folded heading
   // ---------------------------------------------------------------------
   logic                     link_valid [ROTATION_STEPS+1];
   logic                     link_ready [ROTATION_STEPS+1];
   pura_pkg::rot_type        link_data  [ROTATION_STEPS+1];
   logic                     load_valid_ff;
   pura_pkg::rot_type        load_ff;
   pura_pkg::rot_type        load_in;
   logic signed [pura_pkg::VEC_BITS-1:0] start_mag;

   always_comb begin
      start_mag     = signed'(pura_pkg::VEC_BITS'(prep_ff.mag));
      load_in.carry = prep_ff.carry;
      load_in.vx    = prep_ff.flip ? -start_mag : start_mag;
      load_in.vy    = '0;
      load_in.z     = prep_ff.z;
   end

   assign load_ready    = !load_valid_ff || link_ready[0];
   assign link_valid[0] = load_valid_ff;
   assign link_data[0]  = load_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         load_valid_ff <= 1'b0;
      end else if (load_ready) begin
         load_valid_ff <= prep_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ready && prep_valid_ff) begin
         load_ff <= load_in;
      end
   end

   // ---------------------------------------------------------------------
   // cordic: one micro-rotation per stage
   // ---------------------------------------------------------------------
   for (genvar k = 0; k < ROTATION_STEPS; k++) begin : g_rot
      pura_rotate_stage #(
         .STEP (k)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[k]),
         .in_ready  (link_ready[k]),
         .in_data   (link_data[k]),
         .out_valid (link_valid[k+1]),
         .out_ready (link_ready[k+1]),
         .out_data  (link_data[k+1])
      );
   end

   // ---------------------------------------------------------------------
   // rounding to the q16.16 grid and offset add
   // ---------------------------------------------------------------------
   logic                                   sum_valid_ff;
   pura_pkg::sum_type                      sum_ff;
   pura_pkg::sum_type                      sum_in;
   logic                                   sum_ready;
   logic                                   out_ready;
   logic signed [pura_pkg::VEC_BITS-1:0]   rx;
   logic signed [pura_pkg::VEC_BITS-1:0]   ry;
   logic signed [pura_pkg::DELTA_BITS-1:0] dx;
   logic signed [pura_pkg::DELTA_BITS-1:0] dy;

   always_comb begin
      // round half up, then floor shift out the guard bits
      rx = link_data[ROTATION_STEPS].vx + pura_pkg::ROUND_HALF;
      ry = link_data[ROTATION_STEPS].vy + pura_pkg::ROUND_HALF;
      dx = rx[pura_pkg::VEC_BITS-1:pura_pkg::GUARD_BITS];
      dy = ry[pura_pkg::VEC_BITS-1:pura_pkg::GUARD_BITS];
      sum_in.carry = link_data[ROTATION_STEPS].carry;
      sum_in.sx    = pura_pkg::SUM_BITS'(link_data[ROTATION_STEPS].carry.kx)
                   + pura_pkg::SUM_BITS'(dx);
      sum_in.sy    = pura_pkg::SUM_BITS'(link_data[ROTATION_STEPS].carry.ky)
                   + pura_pkg::SUM_BITS'(dy);
   end

   assign sum_ready                  = !sum_valid_ff || out_ready;
   assign link_ready[ROTATION_STEPS] = sum_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (sum_ready) begin
         sum_valid_ff <= link_valid[ROTATION_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (sum_ready && link_valid[ROTATION_STEPS]) begin
         sum_ff <= sum_in;
      end
   end

   // ---------------------------------------------------------------------
   // output register: saturation and change detect
   // ---------------------------------------------------------------------
   logic              out_valid_ff;
   pura_pkg::rsp_type out_ff;
   pura_pkg::rsp_type out_in;

   always_comb begin
      if (sum_ff.sx > pura_pkg::POS_MAX) begin
         out_in.new_x = pura_pkg::POSITION_BITS'(pura_pkg::POS_MAX);
      end else if (sum_ff.sx < pura_pkg::POS_MIN) begin
         out_in.new_x = pura_pkg::POSITION_BITS'(pura_pkg::POS_MIN);
      end else begin
         out_in.new_x = sum_ff.sx[pura_pkg::POSITION_BITS-1:0];
      end
      if (sum_ff.sy > pura_pkg::POS_MAX) begin
         out_in.new_y = pura_pkg::POSITION_BITS'(pura_pkg::POS_MAX);
      end else if (sum_ff.sy < pura_pkg::POS_MIN) begin
         out_in.new_y = pura_pkg::POSITION_BITS'(pura_pkg::POS_MIN);
      end else begin
         out_in.new_y = sum_ff.sy[pura_pkg::POSITION_BITS-1:0];
      end
      out_in.new_heading  = sum_ff.carry.nh;
      out_in.pose_changed = (out_in.new_x != sum_ff.carry.px)
                         || (out_in.new_y != sum_ff.carry.py)
                         || (sum_ff.carry.nh != sum_ff.carry.ph);
   end

   assign out_ready = !out_valid_ff || rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && sum_valid_ff) begin
         out_ff <= out_in;
      end
   end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the pose update core: directed corner cases, then
// random pose requests under random idling, a back-pressure stretch and drain
// pauses; every response is checked against a local bit-exact pose predictor
// ----------------------------------------------------------------------------
module tb;

   // bench timing and traffic shape
   localparam int PIPE_LATENCY = pura_pkg::ROTATION_STEPS + 4;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PCT     = 30;
   localparam int HOLD_CYCLES  = 150;
   localparam int MAX_REPORTS  = 10;

   // predictor formats
   localparam int FRAC_GUARD = 8;
   localparam logic [15:0] ANGLE_HALF = 16'h8000;
   localparam logic [63:0] CORDIC_GAIN = 64'd2608131496;
   localparam logic signed [63:0] POS_HI = 64'sh7FFF_FFFF;
   localparam logic signed [63:0] POS_LO = -POS_HI - 64'sd1;
   localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;

   // arctan(2^-i), 2^32 units per turn
   localparam logic [31:0] ARC_TAN [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   pura_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   pura_pkg::rsp_type rsp_data;

   // poses still owed by the core, oldest first
   pura_pkg::rsp_type pose_expected_q [$];
   int      fail_count  = 0;
   int      cycle_count = 0;
   bit      idle_on     = 1'b1;
   bit      hold_start  = 1'b0;
   int      hold_left   = 0;

   pose_update_via_relative_arc_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: a run that overstays the cycle budget has hung somewhere
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // ------------------------------------------------------------------------
   // pose predictor
   // ------------------------------------------------------------------------
   function automatic pura_pkg::rsp_type pose_predict(input pura_pkg::req_type r);
      logic [15:0] near_tw;
      logic [15:0] far_tw;
      logic [15:0] hd;
      logic [31:0] turn;
      logic        flip;
      logic [63:0] mag;
      logic signed [63:0] vx;
      logic signed [63:0] vy;
      logic signed [63:0] z;
      logic signed [63:0] sx;
      logic signed [63:0] sy;
      logic signed [63:0] nx;
      logic signed [63:0] ny;
      int          i;
      pura_pkg::rsp_type p;
      // conjugate arc when the target sits at the from end
      near_tw = r.target_is_start ? r.arc_end_angle : r.arc_start_angle;
      far_tw  = r.target_is_start ? r.arc_start_angle : r.arc_end_angle;
      hd = r.known_heading - near_tw;
      p.new_heading = hd - ANGLE_HALF + far_tw;

      // fold the heading into [-quarter, quarter) and negate the start vector
      turn = {hd, 16'h0000};
      flip = (turn[31:30] == 2'b01) || (turn[31:30] == 2'b10);
      if (flip)
         turn = turn + 32'h8000_0000;
      z = $signed(turn);

      // start vector is length times the cordic gain, truncated
      mag = {25'd0, r.arc_length, 8'd0};
      mag = ((mag >> 32) * CORDIC_GAIN) + (((mag & 64'hFFFF_FFFF) * CORDIC_GAIN) >> 32);
      vx = $signed(mag);
      if (flip)
         vx = -vx;
      vy = 64'sd0;

      for (i = 0; i < pura_pkg::ROTATION_STEPS && i < 24; i++) begin
         sx = vx >>> i;
         sy = vy >>> i;
         if (z >= 0) begin
            vx = vx - sy;
            vy = vy + sx;
            z  = z - $signed({32'd0, ARC_TAN[i]});
         end else begin
            vx = vx + sy;
            vy = vy - sx;
            z  = z + $signed({32'd0, ARC_TAN[i]});
         end
      end

      // round half up onto the q16.16 grid, add and saturate
      sx = (vx + (64'sd1 <<< (FRAC_GUARD - 1))) >>> FRAC_GUARD;
      sy = (vy + (64'sd1 <<< (FRAC_GUARD - 1))) >>> FRAC_GUARD;
      nx = $signed(r.known_x);
      ny = $signed(r.known_y);
      nx = nx + sx;
      ny = ny + sy;
      if (nx > POS_HI)
         nx = POS_HI;
      else if (nx < POS_LO)
         nx = POS_LO;
      if (ny > POS_HI)
         ny = POS_HI;
      else if (ny < POS_LO)
         ny = POS_LO;
      p.new_x = nx[31:0];
      p.new_y = ny[31:0];
      p.pose_changed = (p.new_x != r.prior_x) || (p.new_y != r.prior_y) ||
                       (p.new_heading != r.prior_heading);
      return p;
   endfunction

   // ------------------------------------------------------------------------
   // request building
   // ------------------------------------------------------------------------
   function automatic pura_pkg::req_type make_request(
      input logic [31:0] kx, input logic [31:0] ky, input logic [15:0] kh,
      input logic [30:0] len, input logic [15:0] sa, input logic [15:0] ea,
      input logic swap, input logic [31:0] px, input logic [31:0] py,
      input logic [15:0] ph);
      pura_pkg::req_type r;
      r.known_x         = kx;
      r.known_y         = ky;
      r.known_heading   = kh;
      r.arc_length      = len;
      r.arc_start_angle = sa;
      r.arc_end_angle   = ea;
      r.target_is_start = swap;
      r.prior_x         = px;
      r.prior_y         = py;
      r.prior_heading   = ph;
      return r;
   endfunction

   // half full-range values, a quarter near the extremes and a quarter near the origin
   function automatic logic [31:0] random_position();
      case ($urandom_range(7))
         0:       return 32'h7FFF_FFFF - $urandom_range(255);
         1:       return 32'h8000_0000 + $urandom_range(255);
         2, 3:    return $urandom_range(2097152) - 32'd1048576;
         default: return $urandom;
      endcase
   endfunction

   // a quarter of the angles land on or next to a quadrant edge
   function automatic logic [15:0] random_angle();
      if ($urandom_range(3) == 0)
         return 16'(($urandom_range(3) << 14) + $urandom_range(2) - 1);
      return 16'($urandom);
   endfunction

   function automatic logic [30:0] random_length();
      case ($urandom_range(3))
         0:       return 31'($urandom);
         1:       return 31'($urandom_range(1048576));
         2:       return LEN_MAX - 31'($urandom_range(15));
         default: return 31'($urandom >> $urandom_range(30));
      endcase
   endfunction

   // prior pose is mostly random; some requests leave the pose untouched
   // and some miss it by a single bit in one field
   function automatic pura_pkg::req_type random_request();
      pura_pkg::req_type r;
      pura_pkg::rsp_type p;
      int                bit_pos;
      r = make_request(random_position(), random_position(), random_angle(),
                       random_length(), random_angle(), random_angle(),
                       1'($urandom_range(1)), $urandom, $urandom, 16'($urandom));
      if ($urandom_range(9) >= 7) begin
         p = pose_predict(r);
         r.prior_x       = p.new_x;
         r.prior_y       = p.new_y;
         r.prior_heading = p.new_heading;
         bit_pos         = $urandom_range(31);
         case ($urandom_range(3))
            0: r.prior_x[bit_pos] = ~r.prior_x[bit_pos];
            1: r.prior_y[bit_pos] = ~r.prior_y[bit_pos];
            2: r.prior_heading = r.prior_heading ^ (16'd1 << $urandom_range(15));
            default: ;
         endcase
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // request driver: optional idle cycles, then hold valid until taken
   // ready is sampled mid-cycle, where it is settled for the coming edge
   // ------------------------------------------------------------------------
   task automatic send_request(input pura_pkg::req_type r);
      bit took;
      if (idle_on) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= r;
      took = 1'b0;
      while (!took) begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end
      pose_expected_q.push_back(pose_predict(r));
   endtask

   // sender goes quiet until every owed pose is back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pose_expected_q.size() != 0)
         @(posedge clock);
      repeat (PIPE_LATENCY)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // response side: random stalls plus a long hold-off on request
   // ------------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (hold_start) begin
            hold_left  = HOLD_CYCLES;
            hold_start = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // response checker, oldest expectation first
   initial begin
      pura_pkg::rsp_type want;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pose_expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("unexpected response at cycle %0d: x %h y %h heading %h changed %b",
                           cycle_count, rsp_data.new_x, rsp_data.new_y,
                           rsp_data.new_heading, rsp_data.pose_changed);
            end else begin
               want = pose_expected_q.pop_front();
               if (rsp_data.new_x !== want.new_x || rsp_data.new_y !== want.new_y ||
                   rsp_data.new_heading !== want.new_heading ||
                   rsp_data.pose_changed !== want.pose_changed) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display(
                        "mismatch @%0d exp x %h y %h h %h c %b got x %h y %h h %h c %b",
                        cycle_count, want.new_x, want.new_y, want.new_heading,
                        want.pose_changed, rsp_data.new_x, rsp_data.new_y,
                        rsp_data.new_heading, rsp_data.pose_changed);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // saturation, quadrant edges, wrap, twist swap, tiny and zero lengths
   task automatic test_directed_cases();
      pura_pkg::req_type r;
      pura_pkg::rsp_type p;
      send_request(make_request(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(0, 0, 0, LEN_MAX, 0, 0, 0, 0, 0, 0));
      // full length along +x from the top of the range
      send_request(make_request(32'h7FFF_FFFF, 0, 0, LEN_MAX, 0, 0, 0, 0, 0, 0));
      // half turn: folded, points along -x from the bottom
      send_request(make_request(32'h8000_0000, 0, 16'h8000, LEN_MAX, 0, 0, 0, 0, 0, 0));
      // plus quarter turn is folded, minus quarter is not
      send_request(make_request(0, 32'h7FFF_FFFF, 16'h4000, LEN_MAX, 0, 0, 0, 0, 0, 0));
      send_request(make_request(0, 32'h8000_0000, 16'hC000, LEN_MAX, 0, 0, 0, 0, 0, 0));
      // either side of the quadrant edges
      send_request(make_request(0, 0, 16'h3FFF, 31'h0100_0000, 0, 0, 0, 0, 0, 0));
      send_request(make_request(0, 0, 16'h4001, 31'h0100_0000, 0, 0, 0, 0, 0, 0));
      send_request(make_request(0, 0, 16'hBFFF, 31'h0100_0000, 0, 0, 0, 0, 0, 0));
      send_request(make_request(0, 0, 16'hC001, 31'h0100_0000, 0, 0, 0, 0, 0, 0));
      // same arc seen from both ends
      send_request(make_request(32'h0001_0000, 32'hFFFF_0000, 16'h1234, 31'h0003_8000,
                                16'h2000, 16'h6000, 1, 0, 0, 0));
      send_request(make_request(32'h0001_0000, 32'hFFFF_0000, 16'h1234, 31'h0003_8000,
                                16'h2000, 16'h6000, 0, 0, 0, 0));
      // heading sums that wrap around the turn
      send_request(make_request(0, 0, 16'h7FFF, 31'h0001_0000, 16'h8000, 16'h7FFF,
                                0, 0, 0, 0));
      // every field at all ones
      send_request(make_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, LEN_MAX,
                                16'hFFFF, 16'hFFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                16'hFFFF));
      // smallest non-zero length
      send_request(make_request(0, 0, 16'h2000, 1, 0, 0, 0, 0, 0, 0));
      // zero length leaving the pose where it was
      send_request(make_request(5, 6, 0, 0, 0, 0, 0, 5, 6, 16'h8000));
      // both axes saturating together
      send_request(make_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h2000, LEN_MAX,
                                0, 0, 0, 0, 0, 0));
      send_request(make_request(32'h8000_0000, 32'h8000_0000, 16'hA000, LEN_MAX,
                                0, 0, 0, 0, 0, 0));
      // unchanged pose, then the same pose missed by one heading unit
      r = make_request(32'h0123_4567, 32'hFEDC_BA98, 16'h1357, 31'h0012_3456,
                       16'h0F0F, 16'hF0F0, 1, 0, 0, 0);
      p = pose_predict(r);
      r.prior_x       = p.new_x;
      r.prior_y       = p.new_y;
      r.prior_heading = p.new_heading;
      send_request(r);
      r.prior_heading = r.prior_heading + 16'd1;
      send_request(r);
   endtask

   task automatic test_random_traffic(input int count);
      repeat (count)
         send_request(random_request());
   endtask

   // back-to-back requests with neither side idling
   task automatic test_no_idle_stretch(input int count);
      idle_on = 1'b0;
      repeat (count)
         send_request(random_request());
      idle_on = 1'b1;
   endtask

   // receiver holds off while the sender keeps pushing, so the pipe fills
   // and the core has to drop req_ready
   task automatic test_receiver_holdoff(input int count);
      idle_on    = 1'b0;
      hold_start = 1'b1;
      repeat (count)
         send_request(random_request());
      idle_on = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (3)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      wait_for_drain();
      test_random_traffic(350);
      test_no_idle_stretch(150);
      test_receiver_holdoff(100);
      wait_for_drain();
      test_random_traffic(200);
      wait_for_drain();
      repeat (PIPE_LATENCY)
         @(posedge clock);

      if (fail_count == 0 && pose_expected_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
